// ===== rtl/waypoint_heading_steering_top_defines.svh =====
// assertion macros for the waypoint heading steering block
`ifndef WAYPOINT_HEADING_STEERING_TOP_DEFINES_SVH
`define WAYPOINT_HEADING_STEERING_TOP_DEFINES_SVH

// check that is masked while reset is high
`define WHS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also runs across reset
`define WHS_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/whs_pkg.sv =====
// types and constants shared by the waypoint heading steering files
`default_nettype none
package whs_pkg;

  localparam int CORDIC_STAGES = 16;
  // deltas and products, sums, setup, two normalize stages
  localparam int CORDIC_FIRST = 5;
  localparam int CONV_STAGE   = CORDIC_FIRST + CORDIC_STAGES;
  localparam int PIPE_DEPTH   = CONV_STAGE + 5;

  localparam logic signed [19:0] PI_Q13     = 20'sd25736;
  localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
  localparam logic signed [31:0] PI_Q29     = 32'sd1686629713;
  localparam logic signed [33:0] HALF_TURN  = 34'sd2147483648;

  // atan(2^-i) in binary angle, one turn = 2^32
  localparam logic [29:0] ATAN_TAB [24] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef enum logic [2:0] {
    REG_HEADING_OFFSET   = 3'd0,
    REG_HEADING_DEADBAND = 3'd1,
    REG_TURN_RATE        = 3'd2,
    REG_FAR_DISTANCE     = 3'd3,
    REG_NEAR_DISTANCE    = 3'd4,
    REG_FAST_SPEED       = 3'd5,
    REG_SLOW_SPEED       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic               navigation_enabled;
    logic               target_valid;
  } in_word_t;

  typedef struct packed {
    logic        [14:0] linear_speed;
    logic signed [15:0] angular_rate;
  } out_word_t;

  typedef struct packed {
    logic signed [43:0] x;
    logic signed [43:0] y;
    logic signed [33:0] z;
  } cord_t;

endpackage
`default_nettype wire

// ===== rtl/waypoint_heading_steering_top.sv =====
// waypoint heading steering: odometry word in, steering command word out
// Input channel: in_valid / in_stall with one odometry sample and waypoint
// per word. Output channel: out_valid / out_stall with speed and yaw rate.
// Samples with navigation disabled, no waypoint, or zero distance to the
// waypoint produce no output word.
// Configuration: cfg_valid / cfg_ready write port, always ready, register
// index on cfg_index and value on cfg_data; write only while idle.
// The pipeline is built from the two side-by-side unrolled CORDIC
// pipelines plus product, normalize and angle conversion stages. One
// word is accepted every cycle while in_stall is low.
// Each stage advances whenever the stage after it is empty or moving, so
// bubbles collapse and new words keep entering while a result waits.
// in_stall rises only when every stage holds a word and out_stall is high.
// Reset (synchronous, rst high) empties the pipeline and restores the
// register defaults.
`default_nettype none
module waypoint_heading_steering_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  whs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output whs_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import whs_pkg::*;

  function automatic cord_t prerot(logic signed [34:0] yv, logic signed [34:0] xv);
    cord_t c;
    c.x = 44'(xv);
    c.y = 44'(yv);
    c.z = '0;
    if (xv < 0) begin
      c.z = (yv >= 0) ? HALF_TURN : -HALF_TURN;
      c.x = -c.x;
      c.y = -c.y;
    end
    return c;
  endfunction

  function automatic cord_t norm_step(cord_t c, int k, int e);
    logic signed [43:0] lim;
    lim = 44'sd1 <<< e;
    if (c.x < lim && c.y < lim && c.y > -lim) begin
      c.x = c.x <<< k;
      c.y = c.y <<< k;
    end
    return c;
  endfunction

  function automatic cord_t cord_iter(cord_t c, int i);
    logic signed [43:0] xs;
    logic signed [43:0] ys;
    logic signed [33:0] a;
    xs = c.x >>> i;
    ys = c.y >>> i;
    a  = $signed(34'(ATAN_TAB[i]));
    if (!c.y[43]) begin
      c.x = c.x + ys;
      c.y = c.y - xs;
      c.z = c.z + a;
    end else begin
      c.x = c.x - ys;
      c.y = c.y + xs;
      c.z = c.z - a;
    end
    return c;
  endfunction

  // configuration registers
  logic [14:0] heading_offset, heading_deadband, turn_rate, fast_speed, slow_speed;
  logic [30:0] far_distance, near_distance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_offset   <= 15'd12868;
      heading_deadband <= 15'd715;
      turn_rate        <= 15'd2860;
      far_distance     <= 31'd131072;
      near_distance    <= 31'd6554;
      fast_speed       <= 15'd4096;
      slow_speed       <= 15'd2048;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADING_OFFSET:   heading_offset   <= cfg_data[14:0];
        REG_HEADING_DEADBAND: heading_deadband <= cfg_data[14:0];
        REG_TURN_RATE:        turn_rate        <= cfg_data[14:0];
        REG_FAR_DISTANCE:     far_distance     <= cfg_data;
        REG_NEAR_DISTANCE:    near_distance    <= cfg_data;
        REG_FAST_SPEED:       fast_speed       <= cfg_data[14:0];
        REG_SLOW_SPEED:       slow_speed       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage advance
  logic [PIPE_DEPTH-1:0] v, en;
  logic dist_zero;

  assign en[PIPE_DEPTH-1] = !v[PIPE_DEPTH-1] || !out_stall;
  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign in_stall  = !en[0];
  assign out_valid = v[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid && in_data.navigation_enabled && in_data.target_valid;
      if (en[1]) v[1] <= v[0] && !dist_zero;
      for (int k = 2; k < PIPE_DEPTH; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: deltas and quaternion products
  logic signed [32:0] s0_dx, s0_dy;
  logic signed [31:0] s0_ww, s0_xx, s0_yy, s0_zz, s0_wz, s0_xy, s0_xz, s0_wy;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dx <= 33'(in_data.target_x) - 33'(in_data.position_x);
      s0_dy <= 33'(in_data.target_y) - 33'(in_data.position_y);
      s0_ww <= in_data.quat_w * in_data.quat_w;
      s0_xx <= in_data.quat_x * in_data.quat_x;
      s0_yy <= in_data.quat_y * in_data.quat_y;
      s0_zz <= in_data.quat_z * in_data.quat_z;
      s0_wz <= in_data.quat_w * in_data.quat_z;
      s0_xy <= in_data.quat_x * in_data.quat_y;
      s0_xz <= in_data.quat_x * in_data.quat_z;
      s0_wy <= in_data.quat_w * in_data.quat_y;
    end
  end

  assign dist_zero = (s0_dx == '0) && (s0_dy == '0);

  // stage 1: quaternion sums and distance squares
  logic [32:0] ax0, ay0;
  logic signed [34:0] s1_d, s1_m20, s1_yx, s1_yy;
  logic signed [32:0] s1_dx, s1_dy;
  logic [61:0] s1_sqx, s1_sqy, s1_far2, s1_near2;
  logic s1_big;

  assign ax0 = s0_dx[32] ? 33'(-s0_dx) : 33'(s0_dx);
  assign ay0 = s0_dy[32] ? 33'(-s0_dy) : 33'(s0_dy);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_d     <= 35'(s0_ww) + 35'(s0_xx) + 35'(s0_yy) + 35'(s0_zz);
      s1_m20   <= (35'(s0_xz) - 35'(s0_wy)) <<< 1;
      s1_yy    <= (35'(s0_wz) + 35'(s0_xy)) <<< 1;
      s1_yx    <= 35'(s0_ww) + 35'(s0_xx) - 35'(s0_yy) - 35'(s0_zz);
      s1_dx    <= s0_dx;
      s1_dy    <= s0_dy;
      s1_sqx   <= ax0[30:0] * ax0[30:0];
      s1_sqy   <= ay0[30:0] * ay0[30:0];
      s1_far2  <= far_distance * far_distance;
      s1_near2 <= near_distance * near_distance;
      s1_big   <= (ax0[32:31] != 2'b00) || (ay0[32:31] != 2'b00);
    end
  end

  // stage 2: pitch check, half-plane fold, distance compare
  logic signed [34:0] m20_abs, yaw_x_in, yaw_y_in;
  logic gimbal;
  logic [62:0] d2;
  logic gt_far, gt_near;
  cord_t s2_a, s2_b;
  logic [14:0] s2_spd;
  logic s2_yz;

  assign m20_abs  = s1_m20[34] ? -s1_m20 : s1_m20;
  assign gimbal   = m20_abs >= s1_d;
  assign yaw_x_in = gimbal ? '0 : s1_yx;
  assign yaw_y_in = gimbal ? '0 : s1_yy;
  assign d2       = 63'(s1_sqx) + 63'(s1_sqy);
  assign gt_far   = s1_big || (d2 > 63'(s1_far2));
  assign gt_near  = s1_big || (d2 > 63'(s1_near2));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_a   <= prerot(yaw_y_in, yaw_x_in);
      s2_b   <= prerot(35'(s1_dy), 35'(s1_dx));
      s2_yz  <= (yaw_x_in == '0) && (yaw_y_in == '0);
      s2_spd <= gt_far ? fast_speed : (gt_near ? slow_speed : 15'd0);
    end
  end

  // stages 3 and 4: scale both vectors up to the 2^40 range
  cord_t s3_a, s3_b;
  logic [14:0] s3_spd;
  logic s3_yz;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_a   <= norm_step(norm_step(norm_step(s2_a, 32, 8), 16, 24), 8, 32);
      s3_b   <= norm_step(norm_step(norm_step(s2_b, 32, 8), 16, 24), 8, 32);
      s3_spd <= s2_spd;
      s3_yz  <= s2_yz;
    end
  end

  cord_t ca [CORDIC_STAGES+1];
  cord_t cb [CORDIC_STAGES+1];
  logic [14:0] spd_p [CORDIC_STAGES+1];
  logic        yz_p  [CORDIC_STAGES+1];

  // last step doubles once more to cross the limit
  always_ff @(posedge clk) begin
    if (en[4]) begin
      ca[0] <= norm_step(norm_step(norm_step(norm_step(s3_a, 4, 36), 2, 38), 1, 39), 1, 40);
      cb[0] <= norm_step(norm_step(norm_step(norm_step(s3_b, 4, 36), 2, 38), 1, 39), 1, 40);
      spd_p[0] <= s3_spd;
      yz_p[0]  <= s3_yz;
    end
  end

  // unrolled vectoring rotations, yaw and bearing side by side
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en[CORDIC_FIRST+i]) begin
        ca[i+1]    <= cord_iter(ca[i], i);
        cb[i+1]    <= cord_iter(cb[i], i);
        spd_p[i+1] <= spd_p[i];
        yz_p[i+1]  <= yz_p[i];
      end
    end
  end

  // binary angle to radians, split into two partial products
  logic signed [49:0] c_alo, c_ahi, c_blo, c_bhi;
  logic [14:0] c_spd;
  logic c_yz;

  always_ff @(posedge clk) begin
    if (en[CONV_STAGE]) begin
      c_alo <= $signed({1'b0, ca[CORDIC_STAGES].z[16:0]}) * PI_Q29;
      c_ahi <= $signed(ca[CORDIC_STAGES].z[33:17]) * PI_Q29;
      c_blo <= $signed({1'b0, cb[CORDIC_STAGES].z[16:0]}) * PI_Q29;
      c_bhi <= $signed(cb[CORDIC_STAGES].z[33:17]) * PI_Q29;
      c_spd <= spd_p[CORDIC_STAGES];
      c_yz  <= yz_p[CORDIC_STAGES];
    end
  end

  logic signed [65:0] tot_a, tot_b;
  logic signed [17:0] r_yaw, r_bear;
  logic [14:0] r_spd;

  assign tot_a = (66'(c_ahi) <<< 17) + 66'(c_alo) + (66'sd1 <<< 46);
  assign tot_b = (66'(c_bhi) <<< 17) + 66'(c_blo) + (66'sd1 <<< 46);

  always_ff @(posedge clk) begin
    if (en[CONV_STAGE+1]) begin
      r_yaw  <= c_yz ? '0 : tot_a[64:47];
      r_bear <= tot_b[64:47];
      r_spd  <= c_spd;
    end
  end

  // heading offset and wrap
  logic signed [19:0] yaw_off, w_yaw;
  logic signed [17:0] w_bear;
  logic [14:0] w_spd;

  assign yaw_off = 20'(r_yaw) + $signed({5'b0, heading_offset});

  always_ff @(posedge clk) begin
    if (en[CONV_STAGE+2]) begin
      w_yaw  <= (yaw_off > PI_Q13) ? yaw_off - TWO_PI_Q13 : yaw_off;
      w_bear <= r_bear;
      w_spd  <= r_spd;
    end
  end

  // heading error, folded to plus or minus pi
  logic signed [19:0] err0, err1, err2, e_err;
  logic [14:0] e_spd;

  always_comb begin
    err0 = w_yaw - 20'(w_bear);
    err1 = (err0 < -PI_Q13) ? err0 + TWO_PI_Q13 : err0;
    err2 = (err1 > PI_Q13) ? err1 - TWO_PI_Q13 : err1;
  end

  always_ff @(posedge clk) begin
    if (en[CONV_STAGE+3]) begin
      e_err <= err2;
      e_spd <= w_spd;
    end
  end

  // deadband decision into the output register
  logic signed [19:0] db;
  logic signed [15:0] rate_pos;

  assign db       = $signed({5'b0, heading_deadband});
  assign rate_pos = $signed({1'b0, turn_rate});

  always_ff @(posedge clk) begin
    if (en[CONV_STAGE+4]) begin
      if (e_err > db) begin
        out_data.linear_speed <= '0;
        out_data.angular_rate <= rate_pos;
      end else if (e_err < -db) begin
        out_data.linear_speed <= '0;
        out_data.angular_rate <= -rate_pos;
      end else begin
        out_data.linear_speed <= e_spd;
        out_data.angular_rate <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/whs_checker.sv =====
// port-level checks for the waypoint heading steering block, with bind
`default_nettype none
`include "waypoint_heading_steering_top_defines.svh"
module whs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input whs_pkg::out_word_t out_data
);
  import whs_pkg::*;

  `WHS_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "output word changed while stalled")
  `WHS_CHECK(a_turn_or_drive, out_valid |-> out_data.linear_speed == 15'd0 || out_data.angular_rate == 16'sd0, "speed and turn both nonzero")
  `WHS_CHECK(a_stall_full, in_stall |-> out_valid && out_stall, "input stalled with output free")
  `WHS_CHECK_RST(a_reset_empty, rst |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind waypoint_heading_steering_top whs_checker u_whs_checker (.*);
`default_nettype wire
